// ===== hdl/tcce_pkg.sv =====
// Shared types and constants for the text console cursor engine.
// No dependencies; every other file of the block but tcce_div imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_SP = 8'h20;

    localparam logic [7:0]  COL_COUNT_RST  = 8'd80;
    localparam logic [15:0] CELL_COUNT_RST = 16'd2000;
    localparam logic [7:0]  ATTR_RST       = 8'd7;

    typedef enum logic [1:0] {
        REG_COL_COUNT     = 2'd0,
        REG_CELL_COUNT    = 2'd1,
        REG_ATTR_DEFAULT  = 2'd2,
        REG_MIRROR_ENABLE = 2'd3
    } tcce_reg_t;

    typedef enum logic [2:0] {
        ACT_MIRROR = 3'd0,
        ACT_WRITE  = 3'd1,
        ACT_SCROLL = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_CURSOR = 3'd4
    } tcce_act_t;

    // Character class decided by the front end.
    typedef enum logic [1:0] {
        CLS_PRINT = 2'd0,
        CLS_CR    = 2'd1,
        CLS_LF    = 2'd2,
        CLS_BS    = 2'd3
    } tcce_cls_t;

    typedef struct packed {
        logic [7:0] ch;
        tcce_cls_t  cls;
    } tcce_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIR_CR,
        S_MIR_CH,
        S_DISP,
        S_WRITE,
        S_DIV_POS,
        S_CHECK,
        S_SCROLL,
        S_DIV_ROW,
        S_CLEAR,
        S_CURSOR
    } tcce_state_t;

    typedef struct packed {
        logic idle;
        logic div_wait;
    } tcce_back_stat_t;

endpackage

`default_nettype wire

// ===== hdl/tcce_if.sv =====
// Valid/ready channel interfaces for characters in and display commands out.
// Depends on tcce_pkg for the action type.
`timescale 1ns / 1ps
`default_nettype none

interface tcce_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

interface tcce_cmd_if
    import tcce_pkg::*;
;
    logic        valid;
    logic        ready;
    tcce_act_t   action;
    logic [15:0] cell_pos;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [15:0] row_index;
    logic        last;

    modport source (output valid, output action, output cell_pos, output char_code,
                    output attribute, output row_index, output last, input ready);
    modport sink (input valid, input action, input cell_pos, input char_code,
                  input attribute, input row_index, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/tcce_front.sv =====
// Front end: accepts character items and classifies them for the back end.
// Depends on tcce_pkg and tcce_if.
`timescale 1ns / 1ps
`default_nettype none

module tcce_front
    import tcce_pkg::*;
(
    tcce_char_if.sink  chars,
    input  wire logic  queue_full,
    output logic       push,
    output tcce_item_t push_item
);

    always_comb
    begin
        push_item.ch = chars.ch;
        case (chars.ch)
            CH_CR:   push_item.cls = CLS_CR;
            CH_LF:   push_item.cls = CLS_LF;
            CH_BS:   push_item.cls = CLS_BS;
            default: push_item.cls = CLS_PRINT;
        endcase
    end

    assign chars.ready = !queue_full;
    assign push        = chars.valid && !queue_full;

endmodule

`default_nettype wire

// ===== hdl/tcce_fifo.sv =====
// Short queue of classified items between the front and back ends.
// Depends on tcce_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module tcce_fifo
    import tcce_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire tcce_item_t push_item,
    input  wire logic       pop,
    output tcce_item_t      head_item,
    output logic            full,
    output logic            not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    tcce_item_t    mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tcce_div.sv =====
// Restoring divider, 16-bit dividend by 8-bit divisor, one quotient bit a cycle.
// Standalone; the back end shares it for row starts and the cleared row.
`timescale 1ns / 1ps
`default_nettype none

module tcce_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] dividend,
    input  wire logic [7:0]  divisor,
    output logic             done,
    output logic [15:0]      quotient,
    output logic [7:0]       remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  step_reg, step_next;
    logic [15:0] quo_reg, quo_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  dsr_reg, dsr_next;
    logic [8:0]  trial;

    assign trial = {rem_reg, quo_reg[15]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // The quotient register shifts the dividend out as quotient bits come in.
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = 8'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = trial[7:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hdl/tcce_back.sv =====
// Back end: sequences the display commands of one item and owns the cursor.
// Depends on tcce_pkg, tcce_if and tcce_div.
`timescale 1ns / 1ps
`default_nettype none

module tcce_back
    import tcce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  col_count,
    input  wire logic [15:0] cell_count,
    input  wire logic [7:0]  attr_default,
    input  wire logic        mirror_enable,
    input  wire logic        queue_not_empty,
    input  wire tcce_item_t  queue_head,
    output logic             pop,
    output tcce_back_stat_t  stat,
    output logic             div_done,
    tcce_cmd_if.source       cmds
);

    tcce_state_t state_reg, state_next;
    tcce_item_t  item_reg, item_next;
    logic [15:0] cursor_reg, cursor_next;
    logic [15:0] target_reg, target_next;

    logic        out_valid_reg, out_valid_next;
    tcce_act_t   out_act_reg;
    logic [15:0] out_pos_reg, out_row_reg;
    logic [7:0]  out_chr_reg, out_attr_reg;
    logic        out_last_reg;

    logic        emit, fire, slot_free;
    tcce_act_t   e_act;
    logic [15:0] e_pos, e_row;
    logic [7:0]  e_chr, e_attr;
    logic        e_last;

    logic        disp_en, bs_noop;
    logic        div_start;
    logic [15:0] div_dvd, div_quo;
    logic [7:0]  div_rem;

    assign disp_en   = (col_count != '0) && (cell_count != '0);
    assign bs_noop   = (item_reg.cls == CLS_BS) && (cursor_reg == '0);
    assign slot_free = !out_valid_reg || cmds.ready;
    assign fire      = emit && slot_free;
    assign div_dvd   = (state_reg == S_SCROLL) ? cell_count : cursor_reg;

    tcce_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (col_count),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        cursor_next = cursor_reg;
        target_next = target_reg;
        pop         = 1'b0;
        div_start   = 1'b0;
        emit        = 1'b0;
        e_act       = ACT_MIRROR;
        e_pos       = '0;
        e_chr       = '0;
        e_attr      = '0;
        e_row       = '0;
        e_last      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (queue_not_empty)
                begin
                    pop       = 1'b1;
                    item_next = queue_head;
                    if (mirror_enable && queue_head.cls == CLS_LF)
                    begin
                        state_next = S_MIR_CR;
                    end
                    else if (mirror_enable && queue_head.cls != CLS_CR)
                    begin
                        state_next = S_MIR_CH;
                    end
                    else
                    begin
                        state_next = S_DISP;
                    end
                end
            end
            S_MIR_CR:
            begin
                emit  = 1'b1;
                e_chr = CH_CR;
                if (fire)
                begin
                    state_next = S_MIR_CH;
                end
            end
            S_MIR_CH:
            begin
                emit   = 1'b1;
                e_chr  = item_reg.ch;
                e_last = !disp_en || bs_noop;
                if (fire)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (!disp_en || bs_noop)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    case (item_reg.cls)
                        CLS_CR, CLS_LF:
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV_POS;
                        end
                        CLS_BS:
                        begin
                            target_next = cursor_reg - 16'd1;
                            state_next  = S_WRITE;
                        end
                        default:
                        begin
                            target_next = cursor_reg;
                            state_next  = S_WRITE;
                        end
                    endcase
                end
            end
            S_WRITE:
            begin
                emit   = 1'b1;
                e_act  = ACT_WRITE;
                e_pos  = target_reg;
                e_chr  = (item_reg.cls == CLS_BS) ? CH_SP : item_reg.ch;
                e_attr = attr_default;
                if (fire)
                begin
                    if (item_reg.cls == CLS_BS)
                    begin
                        cursor_next = target_reg;
                        state_next  = S_CURSOR;
                    end
                    else
                    begin
                        target_next = cursor_reg + 16'd1;
                        state_next  = S_CHECK;
                    end
                end
            end
            S_DIV_POS:
            begin
                if (div_done)
                begin
                    // Start of the next row; wraps modulo 2^16.
                    target_next = cursor_reg - {8'd0, div_rem} + {8'd0, col_count};
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (target_reg >= cell_count)
                begin
                    state_next = S_SCROLL;
                end
                else
                begin
                    cursor_next = target_reg;
                    state_next  = S_CURSOR;
                end
            end
            S_SCROLL:
            begin
                emit  = 1'b1;
                e_act = ACT_SCROLL;
                if (fire)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV_ROW;
                end
            end
            S_DIV_ROW:
            begin
                if (div_done)
                begin
                    target_next = div_quo - 16'd1;
                    state_next  = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                emit  = 1'b1;
                e_act = ACT_CLEAR;
                e_row = target_reg;
                if (fire)
                begin
                    cursor_next = cell_count - {8'd0, col_count};
                    state_next  = S_CURSOR;
                end
            end
            S_CURSOR:
            begin
                emit   = 1'b1;
                e_act  = ACT_CURSOR;
                e_pos  = cursor_reg;
                e_last = 1'b1;
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (cmds.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        target_reg <= target_next;
        if (fire)
        begin
            out_act_reg  <= e_act;
            out_pos_reg  <= e_pos;
            out_chr_reg  <= e_chr;
            out_attr_reg <= e_attr;
            out_row_reg  <= e_row;
            out_last_reg <= e_last;
        end
    end

    assign stat.idle     = (state_reg == S_IDLE);
    assign stat.div_wait = (state_reg == S_DIV_POS) || (state_reg == S_DIV_ROW);

    assign cmds.valid     = out_valid_reg;
    assign cmds.action    = out_act_reg;
    assign cmds.cell_pos  = out_pos_reg;
    assign cmds.char_code = out_chr_reg;
    assign cmds.attribute = out_attr_reg;
    assign cmds.row_index = out_row_reg;
    assign cmds.last      = out_last_reg;

endmodule

`default_nettype wire

// ===== hdl/text_console_cursor_engine_unit.sv =====
// Top level of the text console cursor engine: configuration registers,
// front end, item queue and back end. Depends on tcce_pkg, tcce_if and all tcce modules.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------------
//  chars    | in  | valid/ready        | ch[7:0]
//  cmds     | out | valid/ready        | action, cell_pos, char_code, attribute,
//           |     |                    | row_index, last
//  cfg      | in  | cfg_we, no ready   | cfg_index[1:0], cfg_data[15:0]
//
// An item that causes nothing ends in the dispatch state; a backspace adds a cell write and a
// cursor update, a printable character without scrolling also a bound check, and a mirror
// command adds its own state. CR or LF waits on the shared divider for the row start, and a
// scroll waits on it again for the cleared row; a mirrored LF that scrolls takes longest.
// Each command waits while cmds.ready is low; the queue keeps accepting items until it fills.
// Reset clears the cursor to cell 0 and loads the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_engine_unit
    import tcce_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    tcce_char_if.sink        chars,
    tcce_cmd_if.source       cmds,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [7:0]  col_count_reg, col_count_next;
    logic [15:0] cell_count_reg, cell_count_next;
    logic [7:0]  attr_reg, attr_next;
    logic        mirror_reg, mirror_next;

    logic            push, pop, queue_full, queue_not_empty, div_done;
    tcce_item_t      push_item, head_item;
    tcce_back_stat_t back_stat;

    always_comb
    begin
        col_count_next  = col_count_reg;
        cell_count_next = cell_count_reg;
        attr_next       = attr_reg;
        mirror_next     = mirror_reg;
        if (cfg_we)
        begin
            case (tcce_reg_t'(cfg_index))
                REG_COL_COUNT:     col_count_next  = cfg_data[7:0];
                REG_CELL_COUNT:    cell_count_next = cfg_data;
                REG_ATTR_DEFAULT:  attr_next       = cfg_data[7:0];
                REG_MIRROR_ENABLE: mirror_next     = cfg_data[0];
                default:           col_count_next  = col_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg  <= COL_COUNT_RST;
            cell_count_reg <= CELL_COUNT_RST;
            attr_reg       <= ATTR_RST;
            mirror_reg     <= 1'b0;
        end
        else
        begin
            col_count_reg  <= col_count_next;
            cell_count_reg <= cell_count_next;
            attr_reg       <= attr_next;
            mirror_reg     <= mirror_next;
        end
    end

    tcce_front u_front (
        .chars      (chars),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    tcce_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (queue_full),
        .not_empty (queue_not_empty)
    );

    tcce_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .col_count       (col_count_reg),
        .cell_count      (cell_count_reg),
        .attr_default    (attr_reg),
        .mirror_enable   (mirror_reg),
        .queue_not_empty (queue_not_empty),
        .queue_head      (head_item),
        .pop             (pop),
        .stat            (back_stat),
        .div_done        (div_done),
        .cmds            (cmds)
    );

    // The divider only finishes while the sequencer is waiting on it.
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> back_stat.div_wait)
        else $error("divider finished outside a wait state");

    // A set-cursor command always closes the commands of its item.
    a_cursor_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmds.valid && cmds.action == ACT_CURSOR) |-> cmds.last)
        else $error("set cursor command not marked last");

    // Cell writes, scrolls and row clears are always followed by a cursor update.
    a_never_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmds.valid && (cmds.action == ACT_WRITE || cmds.action == ACT_SCROLL ||
                        cmds.action == ACT_CLEAR)) |-> !cmds.last)
        else $error("command marked last before the cursor update");

    // The sequencer never pops the queue while it is still busy with an item.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (back_stat.idle && queue_not_empty))
        else $error("queue popped while the back end was busy");

endmodule

`default_nettype wire
